/* hdl/wafr_pkg.sv */
// Shared types, constants and helpers for the waveform amplitude core.
package wafr_pkg;

  // ADC code width; fixed by the sample port
  localparam int unsigned SAMPLE_BITS = 12;
  // Default sample-count bound per block
  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  // Block snapshots buffered between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned AMP_BITS = 18;
  localparam int unsigned CNT_BITS = 13;
  localparam int unsigned KFAC_BITS = 18;
  localparam logic [AMP_BITS-1:0] AMP_MAX = '1;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  // waveform_kind codes
  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

  // (65536 * 3.3 / 4096 * 5) squared, the 5 undoing the divide by 5n: 69696 per unit of k
  localparam logic [KFAC_BITS-1:0] KFAC_SQUARE   = 18'd69696;
  localparam logic [KFAC_BITS-1:0] KFAC_SINE     = 18'd139392;
  localparam logic [KFAC_BITS-1:0] KFAC_TRIANGLE = 18'd209088;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_NQ,
    S_MUL_SS,
    S_MUL_K,
    S_SQRT,
    S_DIV,
    S_DONE
  } back_state_e;

  // Scaled waveform factor; the unused code behaves as sine
  function automatic logic [KFAC_BITS-1:0] k_factor(input logic [1:0] kind);
    logic [KFAC_BITS-1:0] f;
    unique case (kind)
      WAVE_SQUARE:   f = KFAC_SQUARE;
      WAVE_TRIANGLE: f = KFAC_TRIANGLE;
      default:       f = KFAC_SINE;
    endcase
    return f;
  endfunction

endpackage

/* hdl/wafr_queue.sv */
// Small register FIFO carrying block snapshots from front to back.
module wafr_queue import wafr_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output q_status_t        status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    fill_q, fill_d;

  assign status_o.empty = (fill_q == '0);
  assign status_o.full  = (fill_q == CW'(DEPTH));
  assign data_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/wafr_front.sv */
// Front end: per-sample accumulation of count, sum and sum of squares.
module wafr_front import wafr_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [SAMPLE_BITS-1:0]               sample_i,
  input  logic                                 last_i,
  input  q_status_t                            q_status_i,
  output logic                                 push_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]     n_o,
  output logic [SAMPLE_BITS+$clog2(MAX_SAMPLES+1)-1:0]   sum_o,
  output logic [2*SAMPLE_BITS+$clog2(MAX_SAMPLES+1)-1:0] sq_o,
  output logic                                 ovf_o
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW = SAMPLE_BITS + CW;
  localparam int unsigned QW = 2 * SAMPLE_BITS + CW;

  logic [CW-1:0]  count_q, count_d;
  logic [SW-1:0]  sum_q, sum_d;
  logic [QW-1:0]  sq_q, sq_d;
  logic           ovf_q, ovf_d;
  logic           accept, room;
  logic [2*SAMPLE_BITS-1:0] sample_sq;

  // a full queue holds off every sample, so a closing sample always has room
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign room       = (count_q < CW'(MAX_SAMPLES));
  assign sample_sq  = sample_i * sample_i;

  // block totals including the current sample
  assign n_o    = room ? count_q + 1'b1 : count_q;
  assign sum_o  = room ? sum_q + SW'(sample_i) : sum_q;
  assign sq_o   = room ? sq_q + QW'(sample_sq) : sq_q;
  assign ovf_o  = ovf_q | ~room;
  assign push_o = accept & last_i;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (last_i) begin
        count_d = '0;
        sum_d   = '0;
        sq_d    = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = n_o;
        sum_d   = sum_o;
        sq_d    = sq_o;
        ovf_d   = ovf_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

/* hdl/wafr_back.sv */
// Back end: variance, waveform scaling, square root and divide, one block at a time.
module wafr_back import wafr_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  q_status_t                            q_status_i,
  output logic                                 pop_o,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]     n_i,
  input  logic [SAMPLE_BITS+$clog2(MAX_SAMPLES+1)-1:0]   sum_i,
  input  logic [2*SAMPLE_BITS+$clog2(MAX_SAMPLES+1)-1:0] sq_i,
  input  logic                                 ovf_i,
  input  logic [1:0]                           waveform_kind_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [AMP_BITS-1:0]                  amplitude_o,
  output logic [CNT_BITS-1:0]                  sample_count_o,
  output logic                                 overflow_o
);

  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW  = SAMPLE_BITS + CW;
  localparam int unsigned QW  = 2 * SAMPLE_BITS + CW;
  localparam int unsigned DW  = 2 * SW;                 // n*Q and S*S both fit
  localparam int unsigned XW  = DW + KFAC_BITS;
  localparam int unsigned RW  = (XW + 1) / 2;           // root width
  localparam int unsigned XP  = 2 * RW;                 // radicand, even width
  localparam int unsigned MW  = (SW > KFAC_BITS) ? SW : KFAC_BITS;
  localparam int unsigned DVW = CW + 3;                 // 5*n
  localparam int unsigned RMW = RW + 2;
  localparam int unsigned IW  = $clog2(RW + 1);

  back_state_e state_q, state_d;

  logic [CW-1:0]        n_q, n_d;
  logic [SW-1:0]        s_q, s_d;
  logic                 ovf_q, ovf_d;
  logic [KFAC_BITS-1:0] kfac_q, kfac_d;
  logic [DVW-1:0]       div_q, div_d;
  logic [DW-1:0]        nq_q, nq_d;
  logic [XP-1:0]        acc_q, acc_d;
  logic [XP-1:0]        mcand_q, mcand_d;
  logic [MW-1:0]        mplier_q, mplier_d;
  logic [RMW-1:0]       srem_q, srem_d;
  logic [RW-1:0]        root_q, root_d;
  logic [DVW:0]         drem_q, drem_d;
  logic [IW-1:0]        iter_q, iter_d;

  logic                  out_valid_q, out_valid_d;
  logic [AMP_BITS-1:0]   amp_q, amp_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  oflag_q, oflag_d;

  logic            mul_done, iter_last, out_free;
  logic [XP-1:0]   acc_step;
  logic [RMW-1:0]  srem_sh, strial;
  logic            sge;
  logic [DVW:0]    dsh, dvs;
  logic            dge;

  assign mul_done  = (mplier_q == '0);
  assign acc_step  = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign iter_last = (iter_q == IW'(RW - 1));
  assign out_free  = ~out_valid_q | ~out_stall_i;

  // restoring square root, two radicand bits per cycle
  assign srem_sh = {srem_q[RMW-3:0], acc_q[XP-1 -: 2]};
  assign strial  = {root_q, 2'b01};
  assign sge     = (srem_sh >= strial);

  // restoring divide of the root by 5n, quotient shifts into root_q
  assign dsh = {drem_q[DVW-1:0], root_q[RW-1]};
  assign dvs = {1'b0, div_q};
  assign dge = (dsh >= dvs);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (!q_status_i.empty) state_d = S_MUL_NQ;
      S_MUL_NQ: if (mul_done) state_d = S_MUL_SS;
      S_MUL_SS: if (mul_done) state_d = S_MUL_K;
      S_MUL_K:  if (mul_done) state_d = S_SQRT;
      S_SQRT:   if (iter_last) state_d = S_DIV;
      S_DIV:    if (iter_last) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop_o       = 1'b0;
    n_d         = n_q;
    s_d         = s_q;
    ovf_d       = ovf_q;
    kfac_d      = kfac_q;
    div_d       = div_q;
    nq_d        = nq_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    srem_d      = srem_q;
    root_d      = root_q;
    drem_d      = drem_q;
    iter_d      = iter_q;
    amp_d       = amp_q;
    cnt_d       = cnt_q;
    oflag_d     = oflag_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o    = 1'b1;
          n_d      = n_i;
          s_d      = sum_i;
          ovf_d    = ovf_i;
          kfac_d   = k_factor(waveform_kind_i);
          div_d    = DVW'({n_i, 2'b00}) + DVW'(n_i);
          acc_d    = '0;
          mcand_d  = XP'(sq_i);
          mplier_d = MW'(n_i);
        end
      end
      S_MUL_NQ, S_MUL_SS, S_MUL_K: begin
        if (!mul_done) begin
          acc_d    = acc_step;
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end else if (state_q == S_MUL_NQ) begin
          nq_d     = acc_q[DW-1:0];
          acc_d    = '0;
          mcand_d  = XP'(s_q);
          mplier_d = MW'(s_q);
        end else if (state_q == S_MUL_SS) begin
          // D = n*Q - S*S, n^2 times the population variance
          acc_d    = '0;
          mcand_d  = XP'(nq_q - acc_q[DW-1:0]);
          mplier_d = MW'(kfac_q);
        end else begin
          srem_d = '0;
          root_d = '0;
          iter_d = '0;
        end
      end
      S_SQRT: begin
        acc_d  = acc_q << 2;
        srem_d = sge ? srem_sh - strial : srem_sh;
        root_d = {root_q[RW-2:0], sge};
        iter_d = iter_q + 1'b1;
        if (iter_last) begin
          iter_d = '0;
          drem_d = '0;
        end
      end
      S_DIV: begin
        drem_d = dge ? dsh - dvs : dsh;
        root_d = {root_q[RW-2:0], dge};
        iter_d = iter_q + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          amp_d   = (64'(root_q) > 64'(AMP_MAX)) ? AMP_MAX : AMP_BITS'(root_q);
          cnt_d   = (32'(n_q) > 32'(CNT_MAX)) ? CNT_MAX : CNT_BITS'(n_q);
          oflag_d = ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign amplitude_o    = amp_q;
  assign sample_count_o = cnt_q;
  assign overflow_o     = oflag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      iter_q      <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    s_q      <= s_d;
    ovf_q    <= ovf_d;
    kfac_q   <= kfac_d;
    div_q    <= div_d;
    nq_q     <= nq_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    srem_q   <= srem_d;
    root_q   <= root_d;
    drem_q   <= drem_d;
    amp_q    <= amp_d;
    cnt_q    <= cnt_d;
    oflag_q  <= oflag_d;
  end

endmodule

/* hdl/waveform_amplitude_from_rms_core.sv */
// Top level of the waveform peak-amplitude meter (RMS times crest factor).
//
// Samples stream in one per cycle unless the input is held off; the front
// end keeps the count, sum and sum of squares of the current block and, on
// the transaction flagged last, pushes a snapshot of the block into a
// four-entry queue. The back end pops one snapshot at a time and works it
// through a shift-add multiplier (n*Q, S*S, then D times the scaled waveform
// factor), a radix-4 restoring square root and a restoring divide by 5n,
// each one bit per cycle. The root is RW bits wide (34 at the default bound
// of 4096 samples). The input is held off only while four finished blocks
// sit in the queue; the result sits in an output register, so the back end
// can start the next block while a result waits. Samples past MAX_SAMPLES
// in one block are dropped and flag overflow. The waveform kind is written
// over its own port (always ready) and should only change while no block is
// in flight.
module waveform_amplitude_from_rms_core import wafr_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample stream
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   last_i,
  // result stream
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [AMP_BITS-1:0]    amplitude_o,
  output logic [CNT_BITS-1:0]    sample_count_o,
  output logic                   overflow_o,
  // waveform kind register
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_waveform_kind_i
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW = SAMPLE_BITS + CW;
  localparam int unsigned QW = 2 * SAMPLE_BITS + CW;
  localparam int unsigned PW = 1 + CW + SW + QW;

  logic [1:0]    waveform_kind_q;
  q_status_t     q_status;
  logic          q_push, q_pop;
  logic [PW-1:0] q_wdata, q_rdata;

  logic [CW-1:0] f_n, b_n;
  logic [SW-1:0] f_sum, b_sum;
  logic [QW-1:0] f_sq, b_sq;
  logic          f_ovf, b_ovf;

  // Config register: always ready, one transaction per valid cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_kind_q <= WAVE_SINE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      waveform_kind_q <= cfg_waveform_kind_i;
    end
  end

  wafr_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .last_i     (last_i),
    .q_status_i (q_status),
    .push_o     (q_push),
    .n_o        (f_n),
    .sum_o      (f_sum),
    .sq_o       (f_sq),
    .ovf_o      (f_ovf)
  );

  // Block snapshot: overflow, count, sum, sum of squares
  assign q_wdata = {f_ovf, f_n, f_sum, f_sq};
  assign {b_ovf, b_n, b_sum, b_sq} = q_rdata;

  wafr_queue #(
    .WIDTH(PW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_wdata),
    .pop_i    (q_pop),
    .data_o   (q_rdata),
    .status_o (q_status)
  );

  wafr_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .pop_o           (q_pop),
    .n_i             (b_n),
    .sum_i           (b_sum),
    .sq_i            (b_sq),
    .ovf_i           (b_ovf),
    .waveform_kind_i (waveform_kind_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .amplitude_o     (amplitude_o),
    .sample_count_o  (sample_count_o),
    .overflow_o      (overflow_o)
  );

  // A block snapshot is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_status.full))
    else $error("snapshot pushed into full queue");

  // The back end only pops a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_status.empty))
    else $error("pop from empty queue");

  // A closing sample leaves at least one snapshot queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> !q_status.empty)
    else $error("closing transaction lost");

  // Every reported block holds at least one sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_count_o != '0))
    else $error("result with zero sample count");

endmodule
